// ===== hdl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int CP_W    = 21;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] PAY2_MASK  = 8'h1F;
  localparam logic [7:0] PAY3_MASK  = 8'h0F;
  localparam logic [7:0] PAY4_MASK  = 8'h07;
  localparam logic [7:0] CONT_PAY   = 8'h3F;

  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;
  localparam logic [2:0] LEN4 = 3'd4;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // Work for one accepted byte: rep_cnt replacement results, then an
  // optional plain code point.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic            tail_vld;
    logic [CP_W-1:0] tail_cp;
    logic            eot;
  } desc_t;

endpackage

// ===== hdl/u8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds result descriptors.
module u8d_front
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        q_ready,
  output logic        q_push,
  output desc_t       q_desc
);

  logic [1:0]      held_r, held_nxt;
  logic [2:0]      len_r, len_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic [2:0]      h_inc;
  logic [2:0]      rep;
  logic            tail_vld;
  logic [CP_W-1:0] tail_cp;
  logic            accept;
  logic [7:0]      b;

  assign b         = in_tdata;
  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;

  always_comb begin
    held_nxt = held_r;
    len_nxt  = len_r;
    part_nxt = part_r;
    rep      = 3'd0;
    tail_vld = 1'b0;
    tail_cp  = '0;
    h_inc    = {1'b0, held_r} + 3'd1;
    if ((held_r != 2'd0) && ((b & CONT_MASK) == CONT_CODE)) begin
      part_nxt = {part_r[CP_W-7:0], b[5:0] & CONT_PAY[5:0]};
      if (h_inc >= len_r) begin
        tail_vld = 1'b1;
        tail_cp  = part_nxt;
        held_nxt = 2'd0;
        len_nxt  = 3'd0;
        part_nxt = '0;
      end else begin
        held_nxt = h_inc[1:0];
      end
    end else begin
      // Any held bytes of a broken sequence each give a replacement.
      rep      = {1'b0, held_r};
      held_nxt = 2'd0;
      len_nxt  = 3'd0;
      part_nxt = '0;
      if (b[7] == 1'b0) begin
        tail_vld = 1'b1;
        tail_cp  = {{(CP_W-8){1'b0}}, b};
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        held_nxt = 2'd1;
        len_nxt  = LEN2;
        part_nxt = {{(CP_W-8){1'b0}}, b & PAY2_MASK};
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        held_nxt = 2'd1;
        len_nxt  = LEN3;
        part_nxt = {{(CP_W-8){1'b0}}, b & PAY3_MASK};
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        held_nxt = 2'd1;
        len_nxt  = LEN4;
        part_nxt = {{(CP_W-8){1'b0}}, b & PAY4_MASK};
      end else begin
        rep = rep + 3'd1;
      end
    end
    if (in_tlast && (held_nxt != 2'd0)) begin
      rep      = rep + {1'b0, held_nxt};
      held_nxt = 2'd0;
      len_nxt  = 3'd0;
      part_nxt = '0;
    end
  end

  assign q_desc.rep_cnt  = rep;
  assign q_desc.tail_vld = tail_vld;
  assign q_desc.tail_cp  = tail_cp;
  assign q_desc.eot      = in_tlast;
  // A lead byte that breaks no held sequence and does not end the text queues nothing.
  assign q_push = accept && ((rep != 3'd0) || tail_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      len_r  <= 3'd0;
      part_r <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
      len_r  <= len_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

// ===== hdl/u8d_queue.sv =====
// Short descriptor queue between the front end and the result sequencer.
module u8d_queue
  import u8d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  ready,
  input  logic  pop,
  output logic  head_vld,
  output desc_t head_desc
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign ready     = (cnt_r != QDEPTH[QPTR_W:0]);
  assign head_vld  = (cnt_r != '0);
  assign head_desc = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== hdl/u8d_back.sv =====
// Result sequencer: expands each descriptor into code points, one per cycle unless stalled.
module u8d_back
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  desc_t       head_desc,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [1:0]      idx_r;
  logic            vld_r;
  logic [CP_W-1:0] cp_r;
  logic            repl_r, last_r, done_r;
  logic [2:0]      total;
  logic            is_last, is_rep, emit;

  assign total   = head_desc.rep_cnt + {2'b00, head_desc.tail_vld};
  assign is_last = ({1'b0, idx_r} == (total - 3'd1));
  assign is_rep  = ({1'b0, idx_r} < head_desc.rep_cnt);
  assign emit    = head_vld && (!vld_r || out_tready);
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      if (emit) begin
        vld_r <= 1'b1;
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r   <= is_rep ? REPL_CP : head_desc.tail_cp;
      repl_r <= is_rep;
      last_r <= is_last;
      done_r <= is_last && head_desc.eot;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, cp_r};
  assign out_tuser  = {done_r, repl_r};
  assign out_tlast  = last_r;

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready   tdata[7:0] text byte, tlast end of text
//  out_     out  out_tvalid/out_tready tdata[20:0] code point, tlast last of run,
//                                      tuser[0] replaced, tuser[1] text done
//
// Each accepted byte is classified in the cycle it is accepted; a byte gives
// zero to four results, and the sequencer sends one result per cycle while
// out_tready is high, so a stream with at most one result per byte runs at
// one byte per cycle. Results pass through the four-entry queue and then the
// output register. Reset clears the held sequence, the queue and out_tvalid.
// Input stalls only when the queue is full; output stalls back up into it.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,  // [0] replaced, [1] text_done
  output logic        out_tlast
);

  logic  q_ready, q_push, q_pop, head_vld;
  desc_t push_desc, head_desc;

  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .ready     (q_ready),
    .pop       (q_pop),
    .head_vld  (head_vld),
    .head_desc (head_desc)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head_desc  (head_desc),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the UTF-8 stream decoder with directed and random byte streams.
module testbench;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 380;
  localparam int CALM_TAIL    = 60;
  localparam int REPORT_MAX   = 10;

  localparam logic [7:0]  CONT_MASK   = 8'hC0;
  localparam logic [7:0]  CONT_CODE   = 8'h80;
  localparam logic [7:0]  TWO_MASK    = 8'hE0;
  localparam logic [7:0]  TWO_CODE    = 8'hC0;
  localparam logic [7:0]  THREE_MASK  = 8'hF0;
  localparam logic [7:0]  THREE_CODE  = 8'hE0;
  localparam logic [7:0]  FOUR_MASK   = 8'hF8;
  localparam logic [7:0]  FOUR_CODE   = 8'hF0;
  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        last_of_run;
    logic        text_done;
  } code_point_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] text_byte
  logic        in_tlast = 1'b0;   // end_of_text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [20:0] code_point, [23:21] zero
  logic [1:0]  out_tuser;         // [0] replaced, [1] text_done
  logic        out_tlast;         // last_of_run

  text_item_t  text_q[$];
  code_point_t cp_expect[$];
  text_item_t  on_bus;
  int          text_total;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;
  bit          send_noisy = 1'b1;
  bit          recv_noisy = 1'b1;
  int          send_gap = 0;
  int          recv_stall = 0;

  // Decoder state as the predictor tracks it.
  logic [2:0]  held_cnt = '0;
  logic [2:0]  seq_len = '0;
  logic [20:0] acc_val = '0;

  utf8_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic code_point_t make_point(logic [20:0] cp, logic repl);
    code_point_t r;
    r = '0;
    r.code_point = cp;
    r.replaced = repl;
    return r;
  endfunction

  // Each held byte of an abandoned sequence turns into one replacement.
  task automatic flush_held(inout code_point_t res[$]);
    for (int k = 0; k < held_cnt; k++) res.push_back(make_point(REPLACEMENT, 1'b1));
    held_cnt = '0;
    seq_len = '0;
    acc_val = '0;
  endtask

  task automatic decode_byte(input text_item_t it);
    code_point_t res[$];
    logic [7:0]  b;
    bit          consumed;
    b = it.text_byte;
    consumed = 0;
    if (held_cnt != 0) begin
      if ((b & CONT_MASK) == CONT_CODE) begin
        acc_val = {acc_val[14:0], b[5:0]};
        held_cnt = held_cnt + 3'd1;
        if (held_cnt >= seq_len) begin
          res.push_back(make_point(acc_val, 1'b0));
          held_cnt = '0;
          seq_len = '0;
          acc_val = '0;
        end
        consumed = 1;
      end else begin
        flush_held(res);
      end
    end
    if (!consumed) begin
      if (b < 8'h80) begin
        res.push_back(make_point({13'd0, b}, 1'b0));
      end else if ((b & TWO_MASK) == TWO_CODE) begin
        seq_len = 3'd2;
        acc_val = {16'd0, b[4:0]};
        held_cnt = 3'd1;
      end else if ((b & THREE_MASK) == THREE_CODE) begin
        seq_len = 3'd3;
        acc_val = {17'd0, b[3:0]};
        held_cnt = 3'd1;
      end else if ((b & FOUR_MASK) == FOUR_CODE) begin
        seq_len = 3'd4;
        acc_val = {18'd0, b[2:0]};
        held_cnt = 3'd1;
      end else begin
        res.push_back(make_point(REPLACEMENT, 1'b1));
      end
    end
    if (it.end_of_text && held_cnt != 0) flush_held(res);
    if (res.size() > 0) begin
      res[res.size()-1].last_of_run = 1'b1;
      res[res.size()-1].text_done = it.end_of_text;
    end
    foreach (res[i]) cp_expect.push_back(res[i]);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.text_byte = b;
    it.end_of_text = eot;
    text_q.push_back(it);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Lead byte of the given length followed by some of its continuation bytes.
  task automatic add_sequence(input int len, input int conts);
    logic [7:0] lead;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    add_byte(lead, $urandom_range(0, 15) == 0);
    for (int k = 0; k < conts; k++) add_byte(cont_byte(), $urandom_range(0, 15) == 0);
  endtask

  task automatic note_mismatch(input string what, input code_point_t want,
                               input code_point_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch (%s): expected cp=%h repl=%b last=%b done=%b, got cp=%h repl=%b last=%b done=%b",
               what, want.code_point, want.replaced, want.last_of_run, want.text_done,
               got.code_point, got.replaced, got.last_of_run, got.text_done);
  endtask

  // Byte driver.
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        decode_byte(on_bus);
        bytes_taken++;
        nv = 1'b0;
      end
      if ($urandom_range(0, 149) == 0) send_noisy = !send_noisy;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (text_q.size() > 0) begin
          if (send_noisy && !calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 12);
          end else begin
            on_bus = text_q.pop_front();
            nv = 1'b1;
            in_tdata <= on_bus.text_byte;
            in_tlast <= on_bus.end_of_text;
          end
        end
      end
      in_tvalid <= nv;
      calm <= (text_q.size() < CALM_TAIL);
    end
  end

  // Code point monitor.
  always @(posedge clk) begin
    code_point_t got;
    code_point_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.code_point = out_tdata[20:0];
        got.replaced = out_tuser[0];
        got.last_of_run = out_tlast;
        got.text_done = out_tuser[1];
        if (cp_expect.size() == 0) begin
          note_mismatch("unexpected item", '0, got);
        end else begin
          want = cp_expect.pop_front();
          if (got.code_point !== want.code_point || got.replaced !== want.replaced ||
              got.last_of_run !== want.last_of_run || got.text_done !== want.text_done)
            note_mismatch("field", want, got);
        end
      end
      if ($urandom_range(0, 149) == 0) recv_noisy = !recv_noisy;
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if (recv_noisy && !calm && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("** utf8_stream_decoder: FAILED **");
    $finish;
  end

  initial begin
    int r;
    int len;
    // Directed opening: extremes, stray bytes, complete, broken and cut-short sequences.
    add_byte(8'h00, 1'b1);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
    add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);
    // A zero byte breaks a held sequence.
    add_byte(8'hE0, 1'b0); add_byte(8'h00, 1'b0);
    // A new lead arrives while two bytes are held.
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
    // The text ends in the middle of a sequence, then on a lone lead byte.
    add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b1);
    add_byte(8'hE1, 1'b1);

    while (text_q.size() < 26 + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(1, 4);
        add_sequence(len, len - 1);
      end else if (r < 75) begin
        len = $urandom_range(2, 4);
        add_sequence(len, $urandom_range(0, len - 2));
      end else if (r < 85) begin
        if ($urandom_range(0, 1) == 0)
          add_byte(cont_byte(), $urandom_range(0, 15) == 0);
        else
          add_byte({5'b11111, 3'($urandom)}, $urandom_range(0, 15) == 0);
      end else begin
        add_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end
    text_total = text_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < text_total || cp_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cp_expect.size() != 0) mismatches += cp_expect.size();
    if (mismatches == 0)
      $display("** utf8_stream_decoder: PASSED **");
    else
      $display("** utf8_stream_decoder: FAILED **");
    $finish;
  end

endmodule
